@@ hdl/rfs_pkg.sv @@
package rfs_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 25;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int SUM_W       = IDX_W + 1;

  // APB register map
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam logic [1:0] REG_RX_ENABLE       = 2'd0;
  localparam logic [1:0] REG_FRAME_MODE      = 2'd1;
  localparam logic [1:0] REG_FAILSAFE_FRAMES = 2'd2;
  localparam logic [7:0] FAILSAFE_FRAMES_RST = 8'd3;

  // Frame format
  localparam logic [7:0] SYNC_BYTE  = 8'h0F;
  localparam logic [7:0] FOOT_A     = 8'h00;
  localparam logic [7:0] FOOT_B     = 8'h04;
  localparam logic [7:0] FOOT_C     = 8'h14;
  localparam logic [7:0] FOOT_D     = 8'h24;
  localparam logic [7:0] FOOT_E     = 8'h34;
  localparam logic [7:0] RSVD_MASK  = 8'hF0;
  localparam logic [7:0] FS_MASK    = 8'h08;
  localparam logic [7:0] RUN_MAX    = 8'hFF;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam idx_t IDX_LAST  = idx_t'(FRAME_BYTES - 1);
  localparam idx_t IDX_FLAGS = idx_t'(FRAME_BYTES - 2);
  localparam idx_t IDX_ONE   = idx_t'(1);
  localparam cnt_t CNT_FULL  = cnt_t'(FRAME_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic       rx_enable;
    logic       frame_mode;
    logic [7:0] failsafe_frames;
  } cfg_t;

  typedef struct packed {
    logic       we;
    idx_t       waddr;
    logic [7:0] wdata;
    logic       re;
    idx_t       raddr;
  } mem_req_t;

  typedef struct packed {
    state_e state;
    idx_t   fill;
  } stat_t;

  // Logical frame position to physical store entry, ring offset by head.
  function automatic idx_t phys_addr(idx_t head, idx_t lidx);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, head} + {1'b0, lidx};
    if (sum >= SUM_W'(FRAME_BYTES)) begin
      sum = sum - SUM_W'(FRAME_BYTES);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic foot_legal(logic [7:0] f);
    return (f == FOOT_A) || (f == FOOT_B) || (f == FOOT_C) ||
           (f == FOOT_D) || (f == FOOT_E);
  endfunction

endpackage

@@ hdl/rfs_if.sv @@
interface rfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       from_frame;
  logic       last_of_run;

  modport source (output valid, output out_byte, output from_frame,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input from_frame,
                input last_of_run, output ready);
endinterface

@@ hdl/rfs_regs.sv @@
module rfs_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rfs_pkg::APB_AW-1:0] paddr,
  input  logic [rfs_pkg::APB_DW-1:0] pwdata,
  output logic [rfs_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output rfs_pkg::cfg_t              cfg_o
);

  rfs_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        rfs_pkg::REG_RX_ENABLE:       cfg_d.rx_enable       = pwdata[0];
        rfs_pkg::REG_FRAME_MODE:      cfg_d.frame_mode      = pwdata[0];
        rfs_pkg::REG_FAILSAFE_FRAMES: cfg_d.failsafe_frames = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rfs_pkg::REG_RX_ENABLE:
        prdata = rfs_pkg::APB_DW'(cfg_q.rx_enable);
      rfs_pkg::REG_FRAME_MODE:
        prdata = rfs_pkg::APB_DW'(cfg_q.frame_mode);
      rfs_pkg::REG_FAILSAFE_FRAMES:
        prdata = rfs_pkg::APB_DW'(cfg_q.failsafe_frames);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rx_enable       <= 1'b0;
      cfg_q.frame_mode      <= 1'b0;
      cfg_q.failsafe_frames <= rfs_pkg::FAILSAFE_FRAMES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/rfs_frame_mem.sv @@
module rfs_frame_mem (
  input  logic               clk_i,
  input  rfs_pkg::mem_req_t  req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [rfs_pkg::FRAME_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rfs_ctrl.sv @@
module rfs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfs_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  input  logic [7:0]         in_byte_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               out_from_frame_o,
  output logic               out_last_o,
  input  logic               out_ready_i,
  output rfs_pkg::mem_req_t  mem_req_o,
  input  logic [7:0]         mem_rdata_i,
  output rfs_pkg::stat_t     stat_o
);

  rfs_pkg::state_e state_q, state_d;
  rfs_pkg::idx_t   fill_q, fill_d;
  rfs_pkg::idx_t   head_q, head_d;
  rfs_pkg::idx_t   ld_idx_q, ld_idx_d;
  rfs_pkg::idx_t   scan_idx_q, scan_idx_d;
  rfs_pkg::cnt_t   rd_idx_q, rd_idx_d;
  logic            pend_q, pend_d;
  logic [7:0]      foot_q, foot_d;
  logic [7:0]      run_q, run_d;
  logic            fs_clr_q, fs_clr_d;
  logic            ov_q, ov_d;
  logic [7:0]      ob_q, ob_d;
  logic            of_q, of_d;
  logic            ol_q, ol_d;

  logic            acc;
  logic            store_en;
  logic            completes;
  logic            good;
  logic            emit_load;
  logic            emit_issue;
  logic            hit;
  logic [7:0]      run_inc;

  assign in_ready_o = (state_q == rfs_pkg::ST_IDLE) &&
                      (!cfg_i.rx_enable || cfg_i.frame_mode || !ov_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign store_en   = acc && cfg_i.rx_enable && cfg_i.frame_mode &&
                      !((fill_q == '0) && (in_byte_i != rfs_pkg::SYNC_BYTE));
  assign completes  = store_en && (fill_q == rfs_pkg::IDX_LAST);

  // flags arrive from the store in CHECK; footer was captured on accept
  assign good       = rfs_pkg::foot_legal(foot_q) &&
                      ((mem_rdata_i & rfs_pkg::RSVD_MASK) == 8'h00);
  assign run_inc    = (run_q == rfs_pkg::RUN_MAX) ? run_q : run_q + 8'd1;

  assign emit_load  = (state_q == rfs_pkg::ST_EMIT) && pend_q && (!ov_q || out_ready_i);
  assign emit_issue = (state_q == rfs_pkg::ST_EMIT) && (rd_idx_q < rfs_pkg::CNT_FULL) &&
                      (!pend_q || emit_load);
  assign hit        = (mem_rdata_i == rfs_pkg::SYNC_BYTE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rfs_pkg::ST_IDLE: begin
        if (completes) begin
          state_d = rfs_pkg::ST_CHECK;
        end
      end
      rfs_pkg::ST_CHECK: begin
        state_d = good ? rfs_pkg::ST_EMIT : rfs_pkg::ST_SCAN;
      end
      rfs_pkg::ST_EMIT: begin
        if (emit_load && (ld_idx_q == rfs_pkg::IDX_LAST)) begin
          state_d = rfs_pkg::ST_IDLE;
        end
      end
      rfs_pkg::ST_SCAN: begin
        if (hit || (scan_idx_q == rfs_pkg::IDX_LAST)) begin
          state_d = rfs_pkg::ST_IDLE;
        end
      end
      default: state_d = rfs_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    fill_d     = fill_q;
    head_d     = head_q;
    ld_idx_d   = ld_idx_q;
    scan_idx_d = scan_idx_q;
    rd_idx_d   = rd_idx_q;
    pend_d     = pend_q;
    foot_d     = foot_q;
    run_d      = run_q;
    fs_clr_d   = fs_clr_q;
    ov_d       = ov_q && !out_ready_i;
    ob_d       = ob_q;
    of_d       = of_q;
    ol_d       = ol_q;
    mem_req_o  = '0;

    case (state_q)
      rfs_pkg::ST_IDLE: begin
        if (acc && cfg_i.rx_enable && !cfg_i.frame_mode) begin
          ov_d = 1'b1;
          ob_d = in_byte_i;
          of_d = 1'b0;
          ol_d = 1'b1;
        end
        if (store_en) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = rfs_pkg::phys_addr(head_q, fill_q);
          mem_req_o.wdata = in_byte_i;
          fill_d          = fill_q + rfs_pkg::IDX_ONE;
        end
        if (completes) begin
          foot_d          = in_byte_i;
          fill_d          = fill_q;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = rfs_pkg::phys_addr(head_q, rfs_pkg::IDX_FLAGS);
        end
      end
      rfs_pkg::ST_CHECK: begin
        rd_idx_d = '0;
        ld_idx_d = '0;
        pend_d   = 1'b0;
        if (good) begin
          if ((mem_rdata_i & rfs_pkg::FS_MASK) != 8'h00) begin
            run_d    = run_inc;
            fs_clr_d = run_inc < cfg_i.failsafe_frames;
          end else begin
            run_d    = '0;
            fs_clr_d = 1'b0;
          end
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = rfs_pkg::phys_addr(head_q, rfs_pkg::IDX_ONE);
          scan_idx_d      = rfs_pkg::IDX_ONE;
        end
      end
      rfs_pkg::ST_EMIT: begin
        if (emit_issue) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = rfs_pkg::phys_addr(head_q, rd_idx_q[rfs_pkg::IDX_W-1:0]);
          rd_idx_d        = rd_idx_q + rfs_pkg::cnt_t'(1);
        end
        pend_d = emit_issue || (pend_q && !emit_load);
        if (emit_load) begin
          ov_d     = 1'b1;
          ob_d     = mem_rdata_i;
          if ((ld_idx_q == rfs_pkg::IDX_FLAGS) && fs_clr_q) begin
            ob_d = mem_rdata_i & ~rfs_pkg::FS_MASK;
          end
          of_d     = 1'b1;
          ol_d     = (ld_idx_q == rfs_pkg::IDX_LAST);
          ld_idx_d = ld_idx_q + rfs_pkg::IDX_ONE;
          if (ld_idx_q == rfs_pkg::IDX_LAST) begin
            fill_d = '0;
          end
        end
      end
      rfs_pkg::ST_SCAN: begin
        if (hit) begin
          // drop everything before the new header by moving the ring head
          head_d = rfs_pkg::phys_addr(head_q, scan_idx_q);
          fill_d = rfs_pkg::idx_t'(rfs_pkg::CNT_FULL - rfs_pkg::cnt_t'(scan_idx_q));
        end else if (scan_idx_q == rfs_pkg::IDX_LAST) begin
          fill_d = '0;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = rfs_pkg::phys_addr(head_q, scan_idx_q + rfs_pkg::IDX_ONE);
          scan_idx_d      = scan_idx_q + rfs_pkg::IDX_ONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfs_pkg::ST_IDLE;
      fill_q  <= '0;
      head_q  <= '0;
      run_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      head_q  <= head_d;
      run_q   <= run_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_idx_q   <= ld_idx_d;
    scan_idx_q <= scan_idx_d;
    rd_idx_q   <= rd_idx_d;
    foot_q     <= foot_d;
    fs_clr_q   <= fs_clr_d;
    ob_q       <= ob_d;
    of_q       <= of_d;
    ol_q       <= ol_d;
  end

  assign out_valid_o      = ov_q;
  assign out_byte_o       = ob_q;
  assign out_from_frame_o = of_q;
  assign out_last_o       = ol_q;
  assign stat_o.state     = state_q;
  assign stat_o.fill      = fill_q;

endmodule

@@ hdl/rc_frame_sync_filter_unit.sv @@
// RC frame sync filter: receive-side byte filter for 25-byte SBUS-style frames.
// rx_i (valid/ready) takes one received byte per word; tx_o (valid/ready)
// gives forwarded bytes with from_frame and last_of_run tags. An APB port
// holds rx_enable (addr 0x0), frame_mode (0x4) and failsafe_frames (0x8).
// Disabled: bytes are taken and dropped. Pass-through: each byte appears on
// tx_o in the cycle after it is taken, through the output register.
// Frame mode: bytes before a header are dropped; from the header on, each byte
// is written into a 25-entry ring store (one write port, one registered read
// port). The byte that completes a frame starts a check: the flags entry is
// read back, then a good frame is streamed out of the store at one word per
// cycle while tx_o is ready. A bad frame is scanned for the next header, one
// store read per cycle; the ring head moves instead of copying.
// rx_i.ready is low while a frame is checked, emitted or scanned; in
// pass-through it also waits for the output register to empty.
// A stalled receiver simply holds the output word and pauses the read stream.
// Reset clears the registers to their defaults, empties the frame and clears
// the failsafe run counter; store contents are not cleared, no pass needed.
module rc_frame_sync_filter_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rfs_in_if.sink                     rx_i,
  rfs_out_if.source                  tx_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rfs_pkg::APB_AW-1:0] paddr,
  input  logic [rfs_pkg::APB_DW-1:0] pwdata,
  output logic [rfs_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  rfs_pkg::cfg_t     cfg;
  rfs_pkg::mem_req_t mem_req;
  rfs_pkg::stat_t    stat;
  logic [7:0]        mem_rdata;

  // configuration registers
  rfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // frame store, ring addressed by the sequencer
  rfs_frame_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // sequencer: accept/store, check, emit, resync scan
  rfs_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (rx_i.valid),
    .in_byte_i        (rx_i.rx_byte),
    .in_ready_o       (rx_i.ready),
    .out_valid_o      (tx_o.valid),
    .out_byte_o       (tx_o.out_byte),
    .out_from_frame_o (tx_o.from_frame),
    .out_last_o       (tx_o.last_of_run),
    .out_ready_i      (tx_o.ready),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata),
    .stat_o           (stat)
  );

  // input is held off while a frame is in flight
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.state != rfs_pkg::ST_IDLE) |-> !rx_i.ready)
    else $error("input ready while sequencer busy");

  // pass-through words are always the last of their run
  a_pass_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_o.valid && !tx_o.from_frame) |-> tx_o.last_of_run)
    else $error("pass-through word without last tag");

  // the partial frame never reaches a full frame at rest
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.fill < rfs_pkg::IDX_LAST) || (stat.fill == rfs_pkg::IDX_LAST))
    else $error("fill count out of range");

  // check only follows the accept of a frame-completing byte
  a_check_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.state == rfs_pkg::ST_CHECK) |-> ($past(stat.state) == rfs_pkg::ST_IDLE))
    else $error("check entered from wrong state");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // Watchdog bound; the worst case puts every frame word behind a long stall.
  localparam int LIMIT_CYCLES = 1_500_000;
  // Bad frame scan is up to 24 store reads plus the check; wait a bit longer.
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int FLAGS_POS    = rfs_pkg::FRAME_BYTES - 2;
  localparam int FOOTER_POS   = rfs_pkg::FRAME_BYTES - 1;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_FOOTER,
    FRM_BAD_FLAGS
  } frame_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       from_frame;
    logic       last;
  } out_word_t;

  logic                       clk = 1'b0;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [rfs_pkg::APB_AW-1:0] paddr;
  logic [rfs_pkg::APB_DW-1:0] pwdata;
  logic [rfs_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  rfs_in_if  rx_if ();
  rfs_out_if tx_if ();

  rc_frame_sync_filter_unit u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .rx_i    (rx_if),
    .tx_o    (tx_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the filter: assembly buffer, fill level, failsafe run, registers.
  logic [7:0] frame_buf [rfs_pkg::FRAME_BYTES];
  int         frame_fill;
  int         fs_run;
  logic       cfg_rx_en;
  logic       cfg_frame_mode;
  logic [7:0] cfg_fs_frames;

  out_word_t  expected_words [$];
  out_word_t  head_word;
  logic [7:0] frame_tx [rfs_pkg::FRAME_BYTES];

  int errors;
  int cycle_count;
  int sent_words;
  int hold_tickets;
  bit quiet;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic bit trailer_valid(logic [7:0] f);
    return (f == rfs_pkg::FOOT_A) || (f == rfs_pkg::FOOT_B) || (f == rfs_pkg::FOOT_C) ||
           (f == rfs_pkg::FOOT_D) || (f == rfs_pkg::FOOT_E);
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic out_word_t mk_word(logic [7:0] d, logic ff, logic lst);
    out_word_t w;
    w.data       = d;
    w.from_frame = ff;
    w.last       = lst;
    return w;
  endfunction

  // Expected words for one accepted rx byte.
  task automatic filter_rx_byte(input logic [7:0] b);
    logic [7:0] flags;
    int         shift;
    if (!cfg_rx_en) return;
    if (!cfg_frame_mode) begin
      expected_words.push_back(mk_word(b, 1'b0, 1'b1));
      return;
    end
    // hunting for a header: anything else is dropped
    if (frame_fill == 0 && b != rfs_pkg::SYNC_BYTE) return;
    if (frame_fill >= rfs_pkg::FRAME_BYTES) frame_fill = 0;
    frame_buf[frame_fill] = b;
    frame_fill++;
    if (frame_fill < rfs_pkg::FRAME_BYTES) return;

    flags = frame_buf[FLAGS_POS];
    if (trailer_valid(frame_buf[FOOTER_POS]) && (flags & rfs_pkg::RSVD_MASK) == 8'h00) begin
      if ((flags & rfs_pkg::FS_MASK) != 8'h00) begin
        if (fs_run < int'(rfs_pkg::RUN_MAX)) fs_run++;
        if (fs_run < int'(cfg_fs_frames)) flags = flags & ~rfs_pkg::FS_MASK;
      end else begin
        fs_run = 0;
      end
      frame_buf[FLAGS_POS] = flags;
      for (int i = 0; i < rfs_pkg::FRAME_BYTES; i++) begin
        expected_words.push_back(mk_word(frame_buf[i], 1'b1,
                                         i == rfs_pkg::FRAME_BYTES - 1));
      end
      frame_fill = 0;
      return;
    end

    // bad frame: realign on the next header in the buffer
    shift = 0;
    for (int i = 1; i < rfs_pkg::FRAME_BYTES; i++) begin
      if (shift == 0 && frame_buf[i] == rfs_pkg::SYNC_BYTE) shift = i;
    end
    if (shift != 0) begin
      for (int i = 0; i < rfs_pkg::FRAME_BYTES - shift; i++) begin
        frame_buf[i] = frame_buf[i + shift];
      end
      frame_fill = rfs_pkg::FRAME_BYTES - shift;
    end else begin
      frame_fill = 0;
    end
  endtask

  // One word on rx: offered at the falling edge, taken at the rising edge with ready.
  task automatic send_word(input logic [7:0] b);
    int gap;
    @(negedge clk);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    filter_rx_byte(b);
    sent_words++;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      rx_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Fills frame_tx; sync_pos > 0 plants an extra header inside the payload.
  task automatic build_frame(input frame_kind_e kind, input bit fs, input int sync_pos);
    logic [7:0] flags;
    logic [7:0] footer;
    int         sel;
    frame_tx[0] = rfs_pkg::SYNC_BYTE;
    for (int i = 1; i < FLAGS_POS; i++) frame_tx[i] = 8'($urandom_range(0, 255));
    if (sync_pos > 0 && sync_pos < FLAGS_POS) frame_tx[sync_pos] = rfs_pkg::SYNC_BYTE;
    flags    = 8'($urandom_range(0, 15));
    flags[3] = fs;
    if (kind == FRM_BAD_FLAGS) flags[7:4] = 4'($urandom_range(1, 15));
    sel = $urandom_range(0, 4);
    case (sel)
      0:       footer = rfs_pkg::FOOT_A;
      1:       footer = rfs_pkg::FOOT_B;
      2:       footer = rfs_pkg::FOOT_C;
      3:       footer = rfs_pkg::FOOT_D;
      default: footer = rfs_pkg::FOOT_E;
    endcase
    if (kind == FRM_BAD_FOOTER) begin
      do footer = 8'($urandom_range(0, 255)); while (trailer_valid(footer));
    end
    frame_tx[FLAGS_POS]  = flags;
    frame_tx[FOOTER_POS] = footer;
  endtask

  task automatic send_span(input int first, input int count);
    for (int i = first; i < first + count && i < rfs_pkg::FRAME_BYTES; i++) begin
      send_word(frame_tx[i]);
    end
  endtask

  task automatic send_frame(input frame_kind_e kind, input bit fs, input int sync_pos);
    build_frame(kind, fs, sync_pos);
    send_span(0, rfs_pkg::FRAME_BYTES);
  endtask

  // Wait for all expected words, then for any silent scan to finish.
  task automatic drain();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic set_reg(input logic [1:0] regsel, input logic [7:0] value);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (regsel)
      rfs_pkg::REG_RX_ENABLE:       cfg_rx_en      = value[0];
      rfs_pkg::REG_FRAME_MODE:      cfg_frame_mode = value[0];
      rfs_pkg::REG_FAILSAFE_FRAMES: cfg_fs_frames  = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Output side: random stalls unless quiet, plus a long hold-off whenever a ticket is raised.
  initial begin : tx_sink
    int hold_left;
    int stall;
    int served;
    hold_left   = 0;
    stall       = 0;
    served      = 0;
    tx_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_tickets) begin
        served    = hold_tickets;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        tx_if.ready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        tx_if.ready <= 1'b1;
      end else if (stall > 0) begin
        tx_if.ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        tx_if.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Every word taken from tx is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_ni && tx_if.valid && tx_if.ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: expected no word, actual out_byte %02h from_frame %0b last_of_run %0b",
                 $time, tx_if.out_byte, tx_if.from_frame, tx_if.last_of_run);
      end else begin
        head_word = expected_words.pop_front();
        if (tx_if.out_byte !== head_word.data) begin
          errors++;
          $display("%0t: out_byte expected %02h actual %02h",
                   $time, head_word.data, tx_if.out_byte);
        end
        if (tx_if.from_frame !== head_word.from_frame) begin
          errors++;
          $display("%0t: from_frame expected %0b actual %0b",
                   $time, head_word.from_frame, tx_if.from_frame);
        end
        if (tx_if.last_of_run !== head_word.last) begin
          errors++;
          $display("%0t: last_of_run expected %0b actual %0b",
                   $time, head_word.last, tx_if.last_of_run);
        end
      end
    end
  end

  // Out of reset the receiver is off: every byte is swallowed.
  task automatic test_disabled_drop();
    send_word(8'h00);
    send_word(8'hFF);
    send_word(rfs_pkg::SYNC_BYTE);
    send_word(8'h5A);
  endtask

  task automatic test_pass_through();
    set_reg(rfs_pkg::REG_RX_ENABLE, 8'd1);
    send_word(8'h00);
    send_word(8'hFF);
    send_word(rfs_pkg::SYNC_BYTE);
    send_word(8'hA5);
    send_word(8'h5A);
  endtask

  // Idle noise, a good frame, reserved flag bits, a bad footer that resyncs.
  task automatic test_frame_checks();
    set_reg(rfs_pkg::REG_FRAME_MODE, 8'd1);
    send_word(8'h00);
    send_word(8'hFF);
    send_frame(FRM_GOOD, 1'b1, 0);
    send_frame(FRM_BAD_FLAGS, 1'b0, 0);
    send_frame(FRM_BAD_FOOTER, 1'b0, 10);
    send_frame(FRM_GOOD, 1'b0, 0);
  endtask

  // Failsafe masking at several thresholds, zero included.
  task automatic test_failsafe_threshold();
    set_reg(rfs_pkg::REG_FAILSAFE_FRAMES, 8'd2);
    repeat (2) send_frame(FRM_GOOD, 1'b1, 0);
    send_frame(FRM_GOOD, 1'b0, 0);
    set_reg(rfs_pkg::REG_FAILSAFE_FRAMES, 8'd0);
    send_frame(FRM_GOOD, 1'b1, 0);
    // a bad frame in the run leaves the counter alone
    set_reg(rfs_pkg::REG_FAILSAFE_FRAMES, rfs_pkg::FAILSAFE_FRAMES_RST);
    send_frame(FRM_GOOD, 1'b1, 0);
    send_frame(FRM_BAD_FLAGS, 1'b1, 0);
    send_frame(FRM_GOOD, 1'b1, 0);
    send_frame(FRM_GOOD, 1'b0, 0);
  endtask

  // The first 10 bytes of a frame, then pass-through and disabled traffic, then the rest of it.
  task automatic test_mode_switch();
    build_frame(FRM_GOOD, 1'b0, 0);
    send_span(0, 10);
    set_reg(rfs_pkg::REG_FRAME_MODE, 8'd0);
    send_word(8'h3C);
    send_word(rfs_pkg::SYNC_BYTE);
    set_reg(rfs_pkg::REG_RX_ENABLE, 8'd0);
    send_word(8'hC3);
    set_reg(rfs_pkg::REG_RX_ENABLE, 8'd1);
    set_reg(rfs_pkg::REG_FRAME_MODE, 8'd1);
    send_span(10, rfs_pkg::FRAME_BYTES - 10);
  endtask

  // Long receiver hold-off while frames keep coming: the input must stall.
  task automatic test_backpressure();
    quiet = 1'b1;
    hold_tickets++;
    repeat (2) send_frame(FRM_GOOD, 1'($urandom_range(0, 1)), 0);
    drain();
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    int         start;
    int         r;
    logic [7:0] fs_val;
    for (int ph = 0; ph < 2; ph++) begin
      fs_val = (ph == 0) ? 8'd1 : 8'($urandom_range(0, 255));
      set_reg(rfs_pkg::REG_FAILSAFE_FRAMES, fs_val);
      set_reg(rfs_pkg::REG_RX_ENABLE, (ph == 1) ? 8'($urandom_range(0, 1)) : 8'd1);
      set_reg(rfs_pkg::REG_FRAME_MODE, 8'd1);
      start = sent_words;
      while (sent_words - start < 15) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_frame(FRM_GOOD, $urandom_range(0, 99) < 60, 0);
        end else if (r < 65) begin
          send_frame(FRM_BAD_FOOTER, 1'($urandom_range(0, 1)),
                     $urandom_range(0, 1) ? $urandom_range(1, FLAGS_POS - 1) : 0);
        end else if (r < 75) begin
          send_frame(FRM_BAD_FLAGS, 1'($urandom_range(0, 1)),
                     $urandom_range(0, 1) ? $urandom_range(1, FLAGS_POS - 1) : 0);
        end else if (r < 85) begin
          build_frame(FRM_GOOD, 1'($urandom_range(0, 1)), 0);
          send_span(0, $urandom_range(1, rfs_pkg::FRAME_BYTES - 1));
        end else begin
          repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    errors        = 0;
    cycle_count   = 0;
    sent_words    = 0;
    hold_tickets  = 0;
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    frame_fill     = 0;
    fs_run         = 0;
    cfg_rx_en      = 1'b0;
    cfg_frame_mode = 1'b0;
    cfg_fs_frames  = rfs_pkg::FAILSAFE_FRAMES_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_disabled_drop();
    test_pass_through();
    test_frame_checks();
    test_failsafe_threshold();
    test_mode_switch();
    test_backpressure();
    test_random_traffic();
    drain();

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
